@@ rtl/core/pcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared types and constants of the prefix-code pixel decoder.
// ----------------------------------------------------------------------------
package pcpd_pkg;

  localparam int DEFAULT_TABLE_DEPTH   = 256;
  localparam int DEFAULT_MAX_CODE_BITS = 32;

  localparam int ENTRY_CODE_W = 32;
  localparam int ENTRY_LEN_W  = 6;
  localparam int COLOR_W      = 8;
  localparam int MODE_W       = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ENTRY_CODE_W-1:0] code;
    logic [ENTRY_LEN_W-1:0]  length;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
  } entry_t;

endpackage

@@ rtl/core/pcpd_table.sv @@
// ----------------------------------------------------------------------------
// pcpd_table
// Code table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcpd_table #(
  parameter int TABLE_DEPTH = pcpd_pkg::DEFAULT_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  pcpd_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output pcpd_pkg::entry_t rd_data
);

  pcpd_pkg::entry_t mem [TABLE_DEPTH];
  pcpd_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/pcpd_match.sv @@
// ----------------------------------------------------------------------------
// pcpd_match
// Shared compare unit: checks one table entry against the pending code.
// ----------------------------------------------------------------------------
module pcpd_match #(
  parameter int MAX_CODE_BITS = pcpd_pkg::DEFAULT_MAX_CODE_BITS,
  localparam int LW = $clog2(MAX_CODE_BITS + 1)
) (
  input  pcpd_pkg::entry_t         entry,
  input  logic [MAX_CODE_BITS-1:0] pend_code,
  input  logic [LW-1:0]            pend_len,
  output logic                     hit
);

  localparam int CMP_W = (MAX_CODE_BITS > pcpd_pkg::ENTRY_CODE_W) ?
                         MAX_CODE_BITS : pcpd_pkg::ENTRY_CODE_W;
  localparam int LCW   = (LW > pcpd_pkg::ENTRY_LEN_W) ? LW : pcpd_pkg::ENTRY_LEN_W;

  logic code_eq;
  logic len_eq;

  assign code_eq = (CMP_W'(entry.code) == CMP_W'(pend_code));
  assign len_eq  = (LCW'(entry.length) == LCW'(pend_len));
  assign hit     = code_eq && len_eq;

endmodule

@@ rtl/core/prefix_code_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// prefix_code_pixel_decoder
// Prefix-code pixel decoder with a loadable code table.
//
// Items arrive on the in_ channel (valid/stall). A load item appends one
// entry (code, length, colour) to the table; it is dropped when the table
// is full. A clear item empties the table and the pending code. Both give
// no result. A decode item shifts one bit into the pending code, then the
// table is searched entry by entry in table order through one read port
// and one comparator. A decode item stalls the input until its search
// ends and any result has moved to the output register; a match ends the
// search early. The search walks the memory read port one entry a cycle,
// with registered read data. A match gives a pixel; reaching MAX_CODE_BITS
// bits without a match gives an overflow result with zero pixel fields.
// Results sit in an output register on the out_ channel. The next item is
// taken while a result waits; a further result waits inside the block until
// the receiver lifts out_stall. Synchronous reset empties the table, clears
// the pending code and drops any result. The table memory is not cleared.
// ----------------------------------------------------------------------------
module prefix_code_pixel_decoder #(
  parameter int TABLE_DEPTH   = pcpd_pkg::DEFAULT_TABLE_DEPTH,
  parameter int MAX_CODE_BITS = pcpd_pkg::DEFAULT_MAX_CODE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pcpd_pkg::MODE_W-1:0]         in_mode,
  input  logic                                in_code_bit,
  input  logic [pcpd_pkg::ENTRY_CODE_W-1:0]   in_entry_code,
  input  logic [pcpd_pkg::ENTRY_LEN_W-1:0]    in_entry_length,
  input  logic [pcpd_pkg::COLOR_W-1:0]        in_entry_red,
  input  logic [pcpd_pkg::COLOR_W-1:0]        in_entry_green,
  input  logic [pcpd_pkg::COLOR_W-1:0]        in_entry_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pcpd_pkg::COLOR_W-1:0]        out_pixel_red,
  output logic [pcpd_pkg::COLOR_W-1:0]        out_pixel_green,
  output logic [pcpd_pkg::COLOR_W-1:0]        out_pixel_blue,
  output logic                                out_code_overflow
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = $clog2(MAX_CODE_BITS + 1);
  localparam int CW    = pcpd_pkg::COLOR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     rvld_r, rvld_nxt;
  logic [MAX_CODE_BITS-1:0] pend_code_r, pend_code_nxt;
  logic [LW-1:0]            pend_len_r, pend_len_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [CW-1:0]            res_red_r, res_red_nxt;
  logic [CW-1:0]            res_green_r, res_green_nxt;
  logic [CW-1:0]            res_blue_r, res_blue_nxt;
  logic                     res_ovf_r, res_ovf_nxt;
  logic [CW-1:0]            out_red_r, out_red_nxt;
  logic [CW-1:0]            out_green_r, out_green_nxt;
  logic [CW-1:0]            out_blue_r, out_blue_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic                     in_accept;
  logic                     out_free;
  logic                     tbl_full;
  logic                     tbl_we;
  logic                     issue;
  logic                     hit;
  pcpd_pkg::entry_t         wr_entry;
  pcpd_pkg::entry_t         rd_entry;

  // Code bits at or above the entry length are stored as zero.
  function automatic logic [pcpd_pkg::ENTRY_CODE_W-1:0] mask_code(
    input logic [pcpd_pkg::ENTRY_CODE_W-1:0] code,
    input logic [pcpd_pkg::ENTRY_LEN_W-1:0]  len
  );
    logic [pcpd_pkg::ENTRY_CODE_W-1:0] m;
    for (int k = 0; k < pcpd_pkg::ENTRY_CODE_W; k++) begin
      m[k] = code[k] && (k < int'(len));
    end
    return m;
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign tbl_full  = (count_r >= CNT_W'(TABLE_DEPTH));
  assign tbl_we    = in_accept && (in_mode == pcpd_pkg::MODE_LOAD) && !tbl_full;
  assign issue     = (idx_r < count_r);

  assign wr_entry.code   = mask_code(in_entry_code, in_entry_length);
  assign wr_entry.length = in_entry_length;
  assign wr_entry.red    = in_entry_red;
  assign wr_entry.green  = in_entry_green;
  assign wr_entry.blue   = in_entry_blue;

  pcpd_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  pcpd_match #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_match (
    .entry     (rd_entry),
    .pend_code (pend_code_r),
    .pend_len  (pend_len_r),
    .hit       (hit)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r + CNT_W'(tbl_we);
    idx_nxt       = idx_r;
    rvld_nxt      = 1'b0;
    pend_code_nxt = pend_code_r;
    pend_len_nxt  = pend_len_r;
    res_red_nxt   = res_red_r;
    res_green_nxt = res_green_r;
    res_blue_nxt  = res_blue_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_mode)
            pcpd_pkg::MODE_DECODE: begin
              pend_code_nxt = {pend_code_r[MAX_CODE_BITS-2:0], in_code_bit};
              pend_len_nxt  = pend_len_r + LW'(1);
              idx_nxt       = '0;
              state_nxt     = ST_SEARCH;
            end
            pcpd_pkg::MODE_CLEAR: begin
              count_nxt     = '0;
              pend_code_nxt = '0;
              pend_len_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (rvld_r && hit) begin
          res_red_nxt   = rd_entry.red;
          res_green_nxt = rd_entry.green;
          res_blue_nxt  = rd_entry.blue;
          res_ovf_nxt   = 1'b0;
          pend_code_nxt = '0;
          pend_len_nxt  = '0;
          state_nxt     = ST_RESULT;
        end else if (!issue && !rvld_r) begin
          if (pend_len_r >= LW'(MAX_CODE_BITS)) begin
            res_red_nxt   = '0;
            res_green_nxt = '0;
            res_blue_nxt  = '0;
            res_ovf_nxt   = 1'b1;
            pend_code_nxt = '0;
            pend_len_nxt  = '0;
            state_nxt     = ST_RESULT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          // Read of the next entry overlaps the compare of the previous one.
          rvld_nxt = issue;
          idx_nxt  = idx_r + CNT_W'(issue);
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_red_nxt   = res_red_r;
          out_green_nxt = res_green_r;
          out_blue_nxt  = res_blue_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rvld_r      <= 1'b0;
      pend_code_r <= '0;
      pend_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rvld_r      <= rvld_nxt;
      pend_code_r <= pend_code_nxt;
      pend_len_r  <= pend_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_red_r   <= res_red_nxt;
    res_green_r <= res_green_nxt;
    res_blue_r  <= res_blue_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_red     = out_red_r;
  assign out_pixel_green   = out_green_r;
  assign out_pixel_blue    = out_blue_r;
  assign out_code_overflow = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pend_len_r < LW'(MAX_CODE_BITS)))
    else $error("pending code left at full length between items");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_mode == pcpd_pkg::MODE_CLEAR) |=>
      (count_r == '0 && pend_len_r == '0))
    else $error("clear item did not empty table and pending code");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result appeared without a finished search");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r |-> (state_r == ST_SEARCH && idx_r <= count_r && idx_r != '0))
    else $error("compare of an entry outside the valid table");

endmodule
